FILE: sv/mmf_pkg.sv
// Shared types and constants for the moving median filter.
// Used by mmf_sort and moving_median_filter_top; depends on nothing else.
package mmf_pkg;

    // Width of a temperature sample in hundredths of a degree.
    localparam int DATA_W = 24;

    // Default window length.
    localparam int WINDOW_DEF = 5;

    // Threshold after reset: -273.15 degrees.
    localparam logic signed [DATA_W-1:0] THRESH_RESET = -24'sd27315;

    typedef logic signed [DATA_W-1:0] t_data;

    // Control of the sorted window for one request.
    typedef struct packed {
        logic commit;   // update the sorted window with the new sample
        logic remove;   // window is full: drop the oldest sample first
    } t_sort_ctl;

endpackage

FILE: sv/moving_median_filter_top.sv
// Top level of the moving median filter: sample memory, pipeline and output register.
// Depends on mmf_pkg and mmf_sort.
//
// Usage:
// Samples arrive on i_sample with i_valid/o_stall; a request is taken at a rising
// edge with i_valid high and o_stall low. Results leave on o_value/o_last with
// o_valid/i_stall; a result is taken at an edge with o_valid high and i_stall low.
// The end threshold is written through i_cfg_we/i_cfg_wdata while the block is idle.
// Each sample is stored in a circular sample memory of WINDOW entries and inserted
// into a sorted copy of the window, while the sample it displaces, read from the
// memory as the sample is taken, is removed. Once WINDOW samples have been seen, each
// sample gives the window median. A sample at or below the threshold is echoed
// with o_last high and empties the window; it gives no median.
// A result passes through stage one, stage two and the output register.
// Throughput: one sample per cycle while the receiver does not stall; the sorted window
// updates as each sample passes and the sample memory takes one read and one write per cycle.
// Reset empties the window, restores the threshold to -273.15 degrees and clears
// the pipeline. While the receiver stalls, the result holds in the output register
// and the two pipeline stages still fill before o_stall rises.
module moving_median_filter_top #(
    parameter int WINDOW = mmf_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [mmf_pkg::DATA_W-1:0] i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [mmf_pkg::DATA_W-1:0] o_value,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic signed [mmf_pkg::DATA_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = $clog2(WINDOW);
    localparam int DW    = mmf_pkg::DATA_W;

    // Threshold register.
    mmf_pkg::t_data r_thresh;

    // Window fill and memory pointer.
    logic [CNT_W-1:0] r_fill;
    logic [PTR_W-1:0] r_wptr;

    // Sample memory and its read data.
    mmf_pkg::t_data r_mem [WINDOW];
    mmf_pkg::t_data r_oldest;

    // Stage one: sample waiting for the sorted window update.
    logic             r_s1_valid;
    logic             r_s1_end;
    logic             r_s1_remove;
    logic             r_s1_result;
    logic [CNT_W-1:0] r_s1_cnt;
    mmf_pkg::t_data   r_s1_sample;

    // Stage two: middle values or echoed end sample.
    logic           r_s2_valid;
    logic           r_s2_last;
    mmf_pkg::t_data r_mid_lo;
    mmf_pkg::t_data r_mid_hi;

    // Output register.
    logic           r_out_valid;
    logic           r_out_last;
    mmf_pkg::t_data r_out_value;

    logic               w_acc;
    logic               w_end;
    logic               w_out_adv;
    logic               w_s2_free;
    logic               w_s1_fire;
    logic               w_s1_free;
    logic [DW:0]        w_sum;
    mmf_pkg::t_sort_ctl w_ctl;
    mmf_pkg::t_data     w_mid_lo;
    mmf_pkg::t_data     w_mid_hi;

    // Flow control: each stage moves on when the one after it is free or moving.
    assign w_out_adv = !r_out_valid || !i_stall;
    assign w_s2_free = !r_s2_valid || w_out_adv;
    assign w_s1_fire = r_s1_valid && w_s2_free;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_stall   = !w_s1_free;
    assign w_acc     = i_valid && w_s1_free;
    assign w_end     = i_sample <= r_thresh;

    // Threshold register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= mmf_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // Fill count and write pointer; an end sample empties the window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wptr <= '0;
        end else if (w_acc) begin
            if (w_end) begin
                r_fill <= '0;
                r_wptr <= '0;
            end else begin
                if (r_fill != CNT_W'(WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_wptr == PTR_W'(WINDOW - 1)) begin
                    r_wptr <= '0;
                end else begin
                    r_wptr <= r_wptr + 1'b1;
                end
            end
        end
    end

    // Sample memory: the entry about to be overwritten is read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_oldest <= r_mem[r_wptr];
            if (!w_end) begin
                r_mem[r_wptr] <= i_sample;
            end
        end
    end

    // Stage one registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_end    <= w_end;
            r_s1_remove <= r_fill == CNT_W'(WINDOW);
            r_s1_result <= r_fill >= CNT_W'(WINDOW - 1);
            r_s1_cnt    <= r_fill;
            r_s1_sample <= i_sample;
        end
    end

    // Sorted window update.
    assign w_ctl.commit = w_s1_fire && !r_s1_end;
    assign w_ctl.remove = r_s1_remove;

    mmf_sort #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W)
    ) u_sort (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_count  (r_s1_cnt),
        .i_sample (r_s1_sample),
        .i_oldest (r_oldest),
        .o_mid_lo (w_mid_lo),
        .o_mid_hi (w_mid_hi)
    );

    // Stage two registers; an end sample is carried in both middle slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_free) begin
            r_s2_valid <= w_s1_fire && (r_s1_end || r_s1_result);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_s2_last <= r_s1_end;
            r_mid_lo  <= r_s1_end ? r_s1_sample : w_mid_lo;
            r_mid_hi  <= r_s1_end ? r_s1_sample : w_mid_hi;
        end
    end

    // Floor of the mean of the middle values; exact when both are equal.
    assign w_sum = {r_mid_lo[DW-1], r_mid_lo} + {r_mid_hi[DW-1], r_mid_hi};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s2_valid) begin
            r_out_value <= w_sum[DW:1];
            r_out_last  <= r_s2_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

    // An end sample empties the window and rewinds the pointer.
    a_end_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_end |=> r_fill == '0 && r_wptr == '0)
        else $error("window not emptied after end sample");

    // Until the window is full, the pointer tracks the fill count.
    a_ptr_tracks_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(WINDOW) |-> CNT_W'(r_wptr) == r_fill)
        else $error("write pointer out of step with fill count");

    // A removal is only requested on a full window.
    a_remove_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_remove |-> r_s1_cnt == CNT_W'(WINDOW) && r_s1_result)
        else $error("removal requested on a window that is not full");

    // A stage that cannot move keeps its request.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s2_free |=> r_s1_valid && $stable(r_s1_sample))
        else $error("stage one request lost while blocked");

endmodule

FILE: sv/mmf_sort.sv
// Sorted copy of the sample window, updated per committed request by one insertion, after one removal when full.
// Depends on mmf_pkg.
module mmf_sort #(
    parameter int WINDOW = mmf_pkg::WINDOW_DEF,
    parameter int CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic              i_clk,
    input  mmf_pkg::t_sort_ctl i_ctl,
    input  logic [CNT_W-1:0]  i_count,
    input  mmf_pkg::t_data    i_sample,
    input  mmf_pkg::t_data    i_oldest,
    output mmf_pkg::t_data    o_mid_lo,
    output mmf_pkg::t_data    o_mid_hi
);

    localparam int MID_LO = (WINDOW - 1) / 2;
    localparam int MID_HI = WINDOW / 2;

    mmf_pkg::t_data r_sorted [WINDOW];
    mmf_pkg::t_data n_sorted [WINDOW];

    // Entries kept after the removal, held in place or moved down by one.
    mmf_pkg::t_data w_kept [WINDOW];
    logic [WINDOW-1:0] w_rm;
    logic [WINDOW-1:0] w_le_new;
    logic [WINDOW-1:0] w_kept_le;
    logic [WINDOW-1:0] w_kept_valid;
    logic [CNT_W-1:0]  w_lim;

    // Number of entries left after the removal step.
    assign w_lim = i_ctl.remove ? CNT_W'(WINDOW - 1) : i_count;

    // Per-cell compares against the oldest and the new sample, all in parallel.
    for (genvar i = 0; i < WINDOW; i++) begin : g_cmp
        assign w_rm[i]         = i_ctl.remove && (r_sorted[i] >= i_oldest);
        assign w_le_new[i]     = r_sorted[i] <= i_sample;
        assign w_kept_valid[i] = CNT_W'(i) < w_lim;
    end

    // Close the gap left by the oldest sample.
    for (genvar i = 0; i < WINDOW; i++) begin : g_kept
        if (i < WINDOW - 1) begin : g_mid
            assign w_kept[i]    = w_rm[i] ? r_sorted[i+1] : r_sorted[i];
            assign w_kept_le[i] = w_kept_valid[i] &&
                                  (w_rm[i] ? w_le_new[i+1] : w_le_new[i]);
        end else begin : g_end
            assign w_kept[i]    = r_sorted[i];
            assign w_kept_le[i] = w_kept_valid[i] && w_le_new[i];
        end
    end

    // Open a slot for the new sample after the last entry not above it.
    for (genvar i = 0; i < WINDOW; i++) begin : g_ins
        if (i == 0) begin : g_first
            assign n_sorted[i] = w_kept_le[i] ? w_kept[i] : i_sample;
        end else begin : g_rest
            assign n_sorted[i] = w_kept_le[i]   ? w_kept[i] :
                                 w_kept_le[i-1] ? i_sample  : w_kept[i-1];
        end
    end

    // Sorted window register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit) begin
            r_sorted <= n_sorted;
        end
    end

    // The middle entries of the updated window.
    assign o_mid_lo = n_sorted[MID_LO];
    assign o_mid_hi = n_sorted[MID_HI];

endmodule
